>>> design/pse_pkg.sv
// Package for the per-source sequence extender: widths, reset values and the
// slot record type. No dependencies.
package pse_pkg;

    localparam int SEQ_W        = 8;
    localparam int ADDR_W       = 16;
    localparam int WRAP_W       = 8;
    localparam int EXT_W        = 16;
    localparam int TABLE_SLOTS  = 128;

    localparam logic [SEQ_W-1:0] WRAP_THRESHOLD_RST = 8'd250;
    localparam logic [ADDR_W-1:0] ADDR_EMPTY        = 16'h0000;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  last_seq;
        logic [WRAP_W-1:0] wrap_count;
    } t_slot;

endpackage

>>> design/pse_in_if.sv
// Input channel of the sequence extender: valid/ready plus packet fields.
// Depends on pse_pkg.
interface pse_in_if;
    logic                        valid;
    logic                        ready;
    logic [pse_pkg::SEQ_W-1:0]   seq_number;
    logic [pse_pkg::ADDR_W-1:0]  source_address;

    modport source (output valid, output seq_number, output source_address, input ready);
    modport sink   (input valid, input seq_number, input source_address, output ready);
endinterface

>>> design/pse_out_if.sv
// Output channel of the sequence extender: valid/ready plus result fields.
// Depends on pse_pkg.
interface pse_out_if;
    logic                       valid;
    logic                       ready;
    logic [pse_pkg::EXT_W-1:0]  extended_number;
    logic                       table_full;

    modport source (output valid, output extended_number, output table_full, input ready);
    modport sink   (input valid, input extended_number, input table_full, output ready);
endinterface

>>> design/per_source_sequence_extender_top.sv
// Per-source sequence extender: slot table in one synchronous RAM, scanned per packet.
// Depends on pse_pkg, pse_in_if, pse_out_if.
//
// Usage:
//   i_in  : one transfer per packet (seq_number, source_address).
//   o_out : one transfer per packet (extended_number, table_full).
//   i_cfg_we / i_cfg_data write wrap_threshold; write only while idle.
// Scan:
//   Slots are claimed in order, so only the first F filled slots are read
//   (F = filled slots, up to TABLE_SLOTS), one RAM read per cycle; a match
//   ends the scan early. The result then passes through S_FINISH into the
//   output register, and no new packet is taken before the FSM returns to
//   S_IDLE.
// Reset:
//   Synchronous, active low. Clears the fill count, so the table reads as
//   empty at once; no clearing pass. Threshold returns to 250.
// Stall:
//   The output register holds a result until taken; a finished scan waits
//   for it to drain, and no new packet is taken meanwhile.
module per_source_sequence_extender_top #(
    parameter int TABLE_SLOTS = pse_pkg::TABLE_SLOTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pse_pkg::SEQ_W-1:0] i_cfg_data,
    pse_in_if.sink                    i_in,
    pse_out_if.source                 o_out
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                          r_state, n_state;
    logic [pse_pkg::SEQ_W-1:0]       r_seq, n_seq;
    logic [pse_pkg::ADDR_W-1:0]      r_addr, n_addr;
    logic [pse_pkg::SEQ_W-1:0]       r_thr, n_thr;
    logic [CNT_W-1:0]                r_fill, n_fill;
    logic [CNT_W-1:0]                r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]                r_cmp_idx, n_cmp_idx;
    logic                            r_cmp_valid, n_cmp_valid;
    logic [pse_pkg::SEQ_W-1:0]       r_zero_last, n_zero_last;
    logic [pse_pkg::WRAP_W-1:0]      r_zero_wrap, n_zero_wrap;
    logic [pse_pkg::EXT_W-1:0]       r_res_ext, n_res_ext;
    logic                            r_res_full, n_res_full;
    logic                            r_out_valid, n_out_valid;
    logic [pse_pkg::EXT_W-1:0]       r_out_ext, n_out_ext;
    logic                            r_out_full, n_out_full;

    pse_pkg::t_slot                  mem [TABLE_SLOTS];
    pse_pkg::t_slot                  r_rd_data;

    logic                            rd_en;
    logic                            we;
    logic [IDX_W-1:0]                waddr;
    pse_pkg::t_slot                  wdata;

    logic                            hit;
    logic                            miss;
    logic [pse_pkg::SEQ_W-1:0]       sel_last;
    logic [pse_pkg::WRAP_W-1:0]      sel_wrap;
    logic signed [pse_pkg::SEQ_W:0]  drop;
    logic                            bump;
    logic [pse_pkg::WRAP_W-1:0]      wrap_new;
    logic                            in_xfer;
    logic                            out_free;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign hit  = (r_state == S_SCAN) && r_cmp_valid && (r_rd_data.addr == r_addr);
    assign miss = (r_state == S_SCAN) && !r_cmp_valid && (r_rd_idx == r_fill);
    assign rd_en = (r_state == S_SCAN) && !hit && (r_rd_idx < r_fill);

    assign sel_last = hit ? r_rd_data.last_seq : r_zero_last;
    assign sel_wrap = hit ? r_rd_data.wrap_count : r_zero_wrap;
    assign drop     = signed'({1'b0, sel_last}) - signed'({1'b0, r_seq});
    assign bump     = drop > signed'({1'b0, r_thr});
    assign wrap_new = sel_wrap + pse_pkg::WRAP_W'(bump);

    always_comb begin
        n_state     = r_state;
        n_seq       = r_seq;
        n_addr      = r_addr;
        n_thr       = r_thr;
        n_fill      = r_fill;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_valid = 1'b0;
        n_zero_last = r_zero_last;
        n_zero_wrap = r_zero_wrap;
        n_res_ext   = r_res_ext;
        n_res_full  = r_res_full;
        n_out_valid = r_out_valid;
        n_out_ext   = r_out_ext;
        n_out_full  = r_out_full;
        we          = 1'b0;
        waddr       = r_cmp_idx;
        wdata       = '{addr: r_addr, last_seq: r_seq, wrap_count: wrap_new};

        if (i_cfg_we) begin
            n_thr = i_cfg_data;
        end
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_seq    = i_in.seq_number;
                    n_addr   = i_in.source_address;
                    n_rd_idx = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_rd_idx    = r_rd_idx + CNT_W'(1);
                    n_cmp_idx   = r_rd_idx[IDX_W-1:0];
                    n_cmp_valid = 1'b1;
                end
                if (hit) begin
                    we         = 1'b1;
                    n_res_ext  = {wrap_new, r_seq};
                    n_res_full = 1'b0;
                    n_state    = S_FINISH;
                end else if (miss) begin
                    n_state = S_FINISH;
                    if (r_fill == FULL_CNT) begin
                        n_res_ext  = '0;
                        n_res_full = 1'b1;
                    end else if (r_addr == pse_pkg::ADDR_EMPTY) begin
                        // empty slot matches address zero but stays empty
                        n_zero_last = r_seq;
                        n_zero_wrap = wrap_new;
                        n_res_ext   = {wrap_new, r_seq};
                        n_res_full  = 1'b0;
                    end else begin
                        we          = 1'b1;
                        waddr       = r_fill[IDX_W-1:0];
                        wdata       = '{addr: r_addr, last_seq: r_seq, wrap_count: '0};
                        n_fill      = r_fill + CNT_W'(1);
                        n_zero_last = '0;
                        n_zero_wrap = '0;
                        n_res_ext   = {{pse_pkg::WRAP_W{1'b0}}, r_seq};
                        n_res_full  = 1'b0;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ext   = r_res_ext;
                    n_out_full  = r_res_full;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= pse_pkg::WRAP_THRESHOLD_RST;
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
            r_zero_last <= '0;
            r_zero_wrap <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_thr       <= n_thr;
            r_fill      <= n_fill;
            r_rd_idx    <= n_rd_idx;
            r_cmp_valid <= n_cmp_valid;
            r_zero_last <= n_zero_last;
            r_zero_wrap <= n_zero_wrap;
            r_out_valid <= n_out_valid;
        end
        r_seq      <= n_seq;
        r_addr     <= n_addr;
        r_cmp_idx  <= n_cmp_idx;
        r_res_ext  <= n_res_ext;
        r_res_full <= n_res_full;
        r_out_ext  <= n_out_ext;
        r_out_full <= n_out_full;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.extended_number = r_out_ext;
    assign o_out.table_full      = r_out_full;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count beyond table size");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_fill == $past(r_fill)) || (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("fill count jumped");

    a_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == S_SCAN) && (hit || miss))
        else $error("table write outside a scan decision");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_full) |-> (r_out_ext == '0))
        else $error("full result with nonzero number");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_valid |-> (r_rd_idx <= r_fill) && (r_state == S_SCAN))
        else $error("compare stage beyond filled slots");

endmodule

>>> tb/per_source_sequence_extender_top_test.sv
// Self-checking testbench for per_source_sequence_extender_top: directed packet table,
// then randomized per-source sequence streams with threshold changes and table fill.
// Depends on pse_pkg, pse_in_if, pse_out_if and the top level.
module per_source_sequence_extender_top_test;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        bit [pse_pkg::EXT_W-1:0] ext;
        bit                      full;
    } t_ext_result;

    typedef struct packed {
        bit [pse_pkg::SEQ_W-1:0]  seq;
        bit [pse_pkg::ADDR_W-1:0] addr;
        bit                       typed;
        bit [pse_pkg::EXT_W-1:0]  ext;
        bit                       full;
    } t_packet_row;

    localparam int N_ROWS = 16;

    // packet rows (typed ones carry a fixed result): claims, address zero, wrap at the threshold boundary
    t_packet_row packet_rows [N_ROWS] = '{
        '{8'hFF, 16'hFFFF, 1'b1, 16'h00FF, 1'b0},
        '{8'h00, 16'hFFFF, 1'b1, 16'h0100, 1'b0},
        '{8'h05, 16'hFFFF, 1'b1, 16'h0105, 1'b0},
        '{8'h00, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{8'hFF, 16'h0000, 1'b1, 16'h00FF, 1'b0},
        '{8'h00, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{8'h10, 16'h1234, 1'b1, 16'h0010, 1'b0},
        '{8'h01, 16'h0001, 1'b1, 16'h0001, 1'b0},
        '{8'h80, 16'h8000, 1'b1, 16'h0080, 1'b0},
        '{8'hFA, 16'h0001, 1'b0, 16'h0000, 1'b0},
        '{8'h00, 16'h0001, 1'b0, 16'h0000, 1'b0},
        '{8'h5A, 16'h5555, 1'b0, 16'h0000, 1'b0},
        '{8'hA5, 16'hAAAA, 1'b0, 16'h0000, 1'b0},
        '{8'hFF, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
        '{8'h00, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{8'h7F, 16'h00FF, 1'b0, 16'h0000, 1'b0}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [pse_pkg::SEQ_W-1:0] i_cfg_data;

    pse_in_if  in_ch ();
    pse_out_if out_ch ();

    per_source_sequence_extender_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    bit [pse_pkg::ADDR_W-1:0] slot_addr_m  [pse_pkg::TABLE_SLOTS];
    bit [pse_pkg::SEQ_W-1:0]  slot_seq_m   [pse_pkg::TABLE_SLOTS];
    bit [pse_pkg::WRAP_W-1:0] slot_wraps_m [pse_pkg::TABLE_SLOTS];
    bit [pse_pkg::SEQ_W-1:0]  threshold_m = pse_pkg::WRAP_THRESHOLD_RST;

    t_ext_result              pending_numbers [$];
    bit [pse_pkg::ADDR_W-1:0] source_pool [$];
    bit [pse_pkg::SEQ_W-1:0]  source_next_seq [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void extend_sequence(input bit [pse_pkg::SEQ_W-1:0] seq,
                                            input bit [pse_pkg::ADDR_W-1:0] addr,
                                            output t_ext_result res);
        int drop;
        for (int i = 0; i < pse_pkg::TABLE_SLOTS; i++) begin
            if (slot_addr_m[i] == addr) begin
                drop = int'(slot_seq_m[i]) - int'(seq);
                if (drop > int'(threshold_m))
                    slot_wraps_m[i] = slot_wraps_m[i] + 1'b1;
                slot_seq_m[i] = seq;
                res.ext  = {slot_wraps_m[i], seq};
                res.full = 1'b0;
                return;
            end
            if (slot_addr_m[i] == pse_pkg::ADDR_EMPTY) begin
                slot_addr_m[i]  = addr;
                slot_seq_m[i]   = seq;
                slot_wraps_m[i] = '0;
                res.ext  = {8'h00, seq};
                res.full = 1'b0;
                return;
            end
        end
        res.ext  = '0;
        res.full = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0d] mismatch %s: got %h want %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_ext_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_numbers.size() == 0) begin
                report_mismatch("unexpected transfer", int'(out_ch.extended_number), 0);
            end else begin
                want = pending_numbers.pop_front();
                if (out_ch.extended_number !== want.ext)
                    report_mismatch("extended_number", int'(out_ch.extended_number),
                                    int'(want.ext));
                if (out_ch.table_full !== want.full)
                    report_mismatch("table_full", int'(out_ch.table_full), int'(want.full));
            end
        end
    end

    initial begin : receiver_stalls
        bit [15:0] stall_pattern;
        int        span;
        out_ch.ready = 1'b0;
        forever begin
            span = $urandom_range(16, 96);
            case ($urandom_range(2))
                0: begin
                    stall_pattern = '1;
                end
                default: begin
                    stall_pattern = 16'($urandom);
                end
            endcase
            repeat (span) begin
                @(negedge i_clk);
                out_ch.ready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    task automatic send_packet(input bit [pse_pkg::SEQ_W-1:0] seq,
                               input bit [pse_pkg::ADDR_W-1:0] addr,
                               input bit typed, input t_ext_result typed_res);
        int          gap;
        t_ext_result res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                @(negedge i_clk);
                in_ch.valid          <= 1'b0;
                in_ch.seq_number     <= pse_pkg::SEQ_W'($urandom);
                in_ch.source_address <= pse_pkg::ADDR_W'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid          <= 1'b1;
        in_ch.seq_number     <= seq;
        in_ch.source_address <= addr;
        @(posedge i_clk);
        while (!(in_ch.valid && in_ch.ready)) @(posedge i_clk);
        extend_sequence(seq, addr, res);
        pending_numbers.push_back(typed ? typed_res : res);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_numbers.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_wrap_threshold(input bit [pse_pkg::SEQ_W-1:0] value);
        wait_for_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= pse_pkg::SEQ_W'($urandom);
        threshold_m = value;
    endtask

    // Mostly in-order streams per source, plus noise, address zero and stray sources.
    task automatic run_phase(input bit [pse_pkg::SEQ_W-1:0] threshold, input int n_items,
                             input int pool_size, input int new_source_pct);
        int                       idx;
        int                       r;
        bit [pse_pkg::SEQ_W-1:0]  seq;
        bit [pse_pkg::ADDR_W-1:0] addr;
        write_wrap_threshold(threshold);
        while (source_pool.size() < pool_size) begin
            source_pool.push_back(pse_pkg::ADDR_W'($urandom_range(1, 65535)));
            source_next_seq.push_back(pse_pkg::SEQ_W'($urandom));
        end
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(99);
            if ($urandom_range(99) < new_source_pct) begin
                source_pool.push_back(pse_pkg::ADDR_W'($urandom_range(1, 65535)));
                source_next_seq.push_back(pse_pkg::SEQ_W'($urandom));
            end
            idx = $urandom_range(source_pool.size() - 1);
            if (new_source_pct > 0 && r < 50)
                idx = source_pool.size() - 1;
            addr = source_pool[idx];
            if (r < 75) begin
                seq = source_next_seq[idx];
                source_next_seq[idx] = seq + pse_pkg::SEQ_W'($urandom_range(1, 3));
            end else if (r < 88) begin
                seq = pse_pkg::SEQ_W'($urandom);
                source_next_seq[idx] = seq + 1'b1;
            end else if (r < 94) begin
                addr = pse_pkg::ADDR_EMPTY;
                seq  = pse_pkg::SEQ_W'($urandom);
            end else begin
                addr = pse_pkg::ADDR_W'($urandom_range(0, 65535));
                seq  = pse_pkg::SEQ_W'($urandom);
            end
            send_packet(seq, addr, 1'b0, '0);
            if ($urandom_range(59) == 0)
                wait_for_drain();
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_data           = '0;
        in_ch.valid          = 1'b0;
        in_ch.seq_number     = '0;
        in_ch.source_address = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_ROWS; k++)
            send_packet(packet_rows[k].seq, packet_rows[k].addr, packet_rows[k].typed,
                        {packet_rows[k].ext, packet_rows[k].full});

        run_phase(8'd0,   140, 10, 0);
        run_phase(8'd255, 140, 16, 0);
        run_phase(pse_pkg::SEQ_W'($urandom), 160, 24, 0);
        run_phase(pse_pkg::WRAP_THRESHOLD_RST, 220, 24, 50);
        run_phase(8'd1,   170, 24, 5);

        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
